FILE: rtl/core/rrts_pkg.sv
// shared types and codes of the round robin time slice scheduler
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned TickW  = 32;
  localparam int unsigned QuantW = 8;

  typedef enum logic [2:0] {
    STATUS_ADDED  = 3'd0,
    STATUS_FULL   = 3'd1,
    STATUS_ZERO   = 3'd2,
    STATUS_IDLE   = 3'd3,
    STATUS_SERVED = 3'd4
  } status_e;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [IdW-1:0]    job_id;
    logic [BurstW-1:0] burst_length;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   served_id;
    logic             finished;
    logic             rotated;
    logic [TickW-1:0] waiting_time;
  } res_t;

endpackage

FILE: rtl/core/round_robin_time_slice_scheduler_unit.sv
// round robin time slice scheduler: top level with ready ring memory
`timescale 1ns / 1ps

// The cycle in which start_i is taken reads the head slot of the ready ring
// from a single-port synchronous memory, the next cycle modifies a served slot
// and writes it back (to the tail slot on rotation, not when the job finishes)
// or appends a new job on an add, and the result appears with result_valid_o
// for one cycle after that, when busy_o is already low again, so a new request
// may be given while it is shown. The receiver cannot stall results. The quantum
// register may be written through cfg_we_i while no request is in flight.

module round_robin_time_slice_scheduler_unit #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  rrts_pkg::req_t                 req_i,
  output logic                           result_valid_o,
  output rrts_pkg::res_t                 result_o,
  input  logic                           cfg_we_i,
  input  logic [rrts_pkg::QuantW-1:0]    cfg_data_i
);

  import rrts_pkg::*;

  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned OccW = $clog2(MAX_JOBS + 1);
  localparam int unsigned SumW = OccW + 1;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] remaining;
    logic [BurstW-1:0] burst;
    logic [TickW-1:0]  join_tick;
  } slot_t;

  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] base,
                                               input logic [OccW-1:0] offset);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(offset);
    if (sum >= SumW'(MAX_JOBS)) begin
      sum = sum - SumW'(MAX_JOBS);
    end
    return sum[IdxW-1:0];
  endfunction

  slot_t mem [MAX_JOBS];

  state_e            state_q, state_d;
  req_t              req_q;
  slot_t             rd_q;
  logic [IdxW-1:0]   head_q, head_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [QuantW-1:0] slice_q, slice_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [QuantW-1:0] quantum_q;
  logic              valid_q;
  res_t              res_q, res_d;

  logic              accept;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  slot_t             mem_wdata;
  slot_t             upd;
  logic [QuantW-1:0] slice_inc;

  assign accept = start_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy_o    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = rd_q;
    head_d    = head_q;
    occ_d     = occ_q;
    slice_d   = slice_q;
    tick_d    = tick_q;
    res_d     = '0;
    upd       = rd_q;
    slice_inc = (slice_q != '1) ? slice_q + QuantW'(1) : slice_q;
    case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_EXEC: begin
        busy_o = 1'b1;
        if (req_q.mode == MODE_ADD) begin
          if (occ_q == OccW'(MAX_JOBS)) begin
            res_d.status = STATUS_FULL;
          end else if (req_q.burst_length == '0) begin
            res_d.status = STATUS_ZERO;
          end else begin
            res_d.status        = STATUS_ADDED;
            mem_we              = 1'b1;
            mem_waddr           = ring_pos(head_q, occ_q);
            mem_wdata.id        = req_q.job_id;
            mem_wdata.remaining = req_q.burst_length;
            mem_wdata.burst     = req_q.burst_length;
            mem_wdata.join_tick = tick_q;
            occ_d               = occ_q + OccW'(1);
          end
        end else begin
          tick_d = tick_q + TickW'(1);
          if (occ_q == '0) begin
            res_d.status = STATUS_IDLE;
          end else begin
            res_d.status    = STATUS_SERVED;
            res_d.served_id = rd_q.id;
            if (rd_q.remaining != '0) begin
              upd.remaining = rd_q.remaining - BurstW'(1);
            end
            slice_d   = slice_inc;
            mem_wdata = upd;
            if (upd.remaining == '0) begin
              res_d.finished     = 1'b1;
              res_d.waiting_time = tick_q + TickW'(1) - rd_q.join_tick
                                   - TickW'(rd_q.burst);
              head_d             = ring_pos(head_q, OccW'(1));
              occ_d              = occ_q - OccW'(1);
              slice_d            = '0;
            end else if (slice_inc >= quantum_q) begin
              res_d.rotated = 1'b1;
              mem_we        = 1'b1;
              mem_waddr     = ring_pos(head_q, occ_q);
              head_d        = ring_pos(head_q, OccW'(1));
              slice_d       = '0;
            end else begin
              mem_we = 1'b1;
            end
          end
        end
      end
      default: busy_o = 1'b0;
    endcase
  end

  // ready ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_EXEC) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      occ_q     <= '0;
      slice_q   <= '0;
      tick_q    <= '0;
      quantum_q <= QuantW'(4);
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      slice_q <= slice_d;
      tick_q  <= tick_d;
      valid_q <= (state_q == ST_EXEC);
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/core/rrts_checker.sv
// port level checks of the round robin time slice scheduler and their binding
`timescale 1ns / 1ps

module rrts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           result_valid_o,
  input rrts_pkg::res_t result_o
);

  import rrts_pkg::*;

  // every request taken while not busy gives its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 result_valid_o)
    else $error("request without result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !result_valid_o)
    else $error("busy not raised after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o && !$past(result_valid_o))
    else $error("result strobe out of place");

  // unused fields stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != STATUS_SERVED |->
      result_o.served_id == '0 && !result_o.finished && !result_o.rotated
      && result_o.waiting_time == '0)
    else $error("unused result fields not clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.finished |-> !result_o.rotated)
    else $error("finished job rotated");

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

FILE: sim/round_robin_time_slice_scheduler_unit_test.sv
// self-checking testbench of the round robin time slice scheduler unit
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_unit_test;

  import rrts_pkg::*;

  localparam int unsigned JOBS          = 16;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned DRAIN_CAP     = 16;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic              busy_o;
  req_t              req_i      = '0;
  logic              result_valid_o;
  res_t              result_o;
  logic              cfg_we_i   = 1'b0;
  logic [QuantW-1:0] cfg_data_i = '0;

  req_t pending_requests[$];
  res_t expected_outcomes[$];
  logic steady_sender  = 1'b0;
  logic mismatch_seen  = 1'b0;
  int unsigned quiet_cycles = 0;

  // scheduler state as the testbench sees it
  logic [IdW-1:0]    ring_id     [JOBS];
  logic [BurstW-1:0] ring_left   [JOBS];
  logic [BurstW-1:0] ring_burst  [JOBS];
  logic [TickW-1:0]  ring_joined [JOBS];
  int unsigned       head_q      = 0;
  int unsigned       occ_q       = 0;
  logic [7:0]        slice_q     = '0;
  logic [TickW-1:0]  now_q       = '0;
  logic [QuantW-1:0] quantum_q   = 8'd4;

  round_robin_time_slice_scheduler_unit #(
    .MAX_JOBS(JOBS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic req_t job_request(mode_e m, logic [IdW-1:0] id, logic [BurstW-1:0] b);
    req_t r;
    r.mode         = m;
    r.job_id       = id;
    r.burst_length = b;
    return r;
  endfunction

  function automatic res_t scheduler_step(req_t rq);
    res_t        r;
    int unsigned h;
    int unsigned t;
    r        = '0;
    r.status = STATUS_ADDED;
    if (rq.mode == MODE_ADD) begin
      if (occ_q >= JOBS) begin
        r.status = STATUS_FULL;
      end else if (rq.burst_length == '0) begin
        r.status = STATUS_ZERO;
      end else begin
        t              = (head_q + occ_q) % JOBS;
        ring_id[t]     = rq.job_id;
        ring_left[t]   = rq.burst_length;
        ring_burst[t]  = rq.burst_length;
        ring_joined[t] = now_q;
        occ_q++;
      end
    end else begin
      now_q = now_q + 1'b1;
      if (occ_q == 0) begin
        r.status = STATUS_IDLE;
      end else begin
        h           = head_q;
        r.status    = STATUS_SERVED;
        r.served_id = ring_id[h];
        if (ring_left[h] != '0) ring_left[h] = ring_left[h] - 1'b1;
        if (slice_q != 8'hFF) slice_q = slice_q + 1'b1;
        if (ring_left[h] == '0) begin
          r.finished     = 1'b1;
          r.waiting_time = now_q - ring_joined[h] - TickW'(ring_burst[h]);
          head_q         = (h + 1) % JOBS;
          occ_q--;
          slice_q        = '0;
        end else if (slice_q >= quantum_q) begin
          t              = (h + occ_q) % JOBS;
          r.rotated      = 1'b1;
          ring_id[t]     = ring_id[h];
          ring_left[t]   = ring_left[h];
          ring_burst[t]  = ring_burst[h];
          ring_joined[t] = ring_joined[h];
          head_q         = (h + 1) % JOBS;
          slice_q        = '0;
        end
      end
    end
    return r;
  endfunction

  task automatic wait_settled();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [QuantW-1:0] q);
    wait_settled();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    quantum_q   = q;
    @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_outcomes.push_back(scheduler_step(req_i));
        void'(pending_requests.pop_front());
      end
      if (!start_i || !busy_o) begin
        if (pending_requests.size() != 0 && (steady_sender || $urandom_range(99) >= 37)) begin
          start_i <= 1'b1;
          req_i   <= pending_requests[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d", result_o.status);
        mismatch_seen = 1'b1;
      end else begin
        exp_r = expected_outcomes.pop_front();
        if (result_o.status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, result_o.status);
          mismatch_seen = 1'b1;
        end
        if (result_o.served_id !== exp_r.served_id) begin
          $error("served_id expected %0d got %0d", exp_r.served_id, result_o.served_id);
          mismatch_seen = 1'b1;
        end
        if (result_o.finished !== exp_r.finished) begin
          $error("finished expected %0d got %0d", exp_r.finished, result_o.finished);
          mismatch_seen = 1'b1;
        end
        if (result_o.rotated !== exp_r.rotated) begin
          $error("rotated expected %0d got %0d", exp_r.rotated, result_o.rotated);
          mismatch_seen = 1'b1;
        end
        if (result_o.waiting_time !== exp_r.waiting_time) begin
          $error("waiting_time expected %0d got %0d", exp_r.waiting_time,
                 result_o.waiting_time);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("round_robin_time_slice_scheduler_unit_test: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned        left_total;
    int unsigned        add_pct;
    int unsigned        pick;
    logic [BurstW-1:0]  b;
    logic [QuantW-1:0]  phase_quantum [PHASES];

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, zero burst, widest job, then fill the ring and add to it while full
    pending_requests.push_back(job_request(MODE_TICK, 8'hFF, 16'hFFFF));
    pending_requests.push_back(job_request(MODE_ADD, 8'h00, 16'h0000));
    pending_requests.push_back(job_request(MODE_ADD, 8'hFF, 16'hFFFF));
    for (int i = 1; i < JOBS; i++) begin
      pending_requests.push_back(job_request(MODE_ADD, IdW'(i), BurstW'(i % 6 + 1)));
    end
    pending_requests.push_back(job_request(MODE_ADD, 8'h5A, 16'h0000));
    pending_requests.push_back(job_request(MODE_ADD, 8'hAA, 16'h0003));
    repeat (5) pending_requests.push_back(job_request(MODE_TICK, 8'h00, 16'h0000));
    wait_settled();

    // serve the queued jobs for a while, the widest one never finishes
    left_total = 0;
    for (int k = 0; k < occ_q; k++) begin
      left_total += (ring_left[(head_q + k) % JOBS] > DRAIN_CAP) ? DRAIN_CAP
                    : ring_left[(head_q + k) % JOBS];
    end
    repeat (left_total) pending_requests.push_back(
      job_request(MODE_TICK, IdW'($urandom), BurstW'($urandom)));
    wait_settled();

    phase_quantum[0] = 8'd0;
    phase_quantum[1] = 8'd1;
    phase_quantum[2] = 8'd255;
    phase_quantum[3] = QuantW'($urandom_range(6, 2));
    phase_quantum[4] = 8'd3;
    for (int p = 0; p < PHASES; p++) begin
      write_quantum(phase_quantum[p]);
      steady_sender = (p == 1);
      add_pct       = (p % 2 == 0) ? 55 : 42;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < add_pct) begin
          pick = $urandom_range(99);
          if (pick < 7) b = '0;
          else if (pick < 12) b = BurstW'($urandom_range(300, 11));
          else b = BurstW'($urandom_range(10, 1));
          pending_requests.push_back(job_request(MODE_ADD, IdW'($urandom), b));
        end else begin
          pending_requests.push_back(job_request(MODE_TICK, IdW'($urandom), BurstW'($urandom)));
        end
      end
    end
    steady_sender = 1'b0;
    wait_settled();
    repeat (10) @(posedge clk_i);

    if (!mismatch_seen) begin
      $display("round_robin_time_slice_scheduler_unit_test: PASS");
    end else begin
      $display("round_robin_time_slice_scheduler_unit_test: FAIL");
    end
    $finish;
  end

endmodule
